### design/vfcm_pkg.sv
// shared types, constants and lookup functions for the voxel face culling mesher
`timescale 1ns / 1ps

package vfcm_pkg;

	// chunk geometry
	localparam int CHUNK_EDGE  = 8;
	localparam int VOXEL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int ADDR_W      = $clog2(VOXEL_COUNT);

	// field widths
	localparam int VOX_W   = 3;
	localparam int TYPE_W  = 2;
	localparam int CHUNK_W = 16;
	localparam int COORD_W = 20;
	localparam int BASE_W  = 22;
	localparam int CFG_IDX_W = 2;
	localparam int FACES   = 6;

	// world coordinate clamp range
	localparam int COORD_MAX = 262144;
	localparam int COORD_MIN = -262144;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Z = 2'd2;

	// block types
	localparam logic [TYPE_W-1:0] TYPE_AIR     = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_UNUSED  = 2'd3;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_MESH  = 1'b1;

	// face order: x-, y-, z-, x+, y+, z+
	localparam logic [2:0] FACE_XN = 3'd0;
	localparam logic [2:0] FACE_YN = 3'd1;
	localparam logic [2:0] FACE_ZN = 3'd2;
	localparam logic [2:0] FACE_XP = 3'd3;
	localparam logic [2:0] FACE_YP = 3'd4;
	localparam logic [2:0] FACE_ZP = 3'd5;

	// classified request word between front and back
	typedef struct packed {
		logic              is_mesh;
		logic [VOX_W-1:0]  x;
		logic [VOX_W-1:0]  y;
		logic [VOX_W-1:0]  z;
		logic [TYPE_W-1:0] new_type;
		logic              in_chunk;
		logic [FACES-1:0]  nbr_in;
	} front_item_t;

	// one result word
	typedef struct packed {
		logic [COORD_W-1:0] corner_a_x;
		logic [COORD_W-1:0] corner_a_y;
		logic [COORD_W-1:0] corner_a_z;
		logic [COORD_W-1:0] corner_b_x;
		logic [COORD_W-1:0] corner_b_y;
		logic [COORD_W-1:0] corner_b_z;
		logic [COORD_W-1:0] corner_c_x;
		logic [COORD_W-1:0] corner_c_y;
		logic [COORD_W-1:0] corner_c_z;
		logic [TYPE_W-1:0]  face_type;
		logic               tri_valid;
		logic               last_tri;
	} tri_word_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EMIT
	} bk_state_t;

	// linear store address of a voxel
	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic [VOX_W-1:0] x,
		input logic [VOX_W-1:0] y,
		input logic [VOX_W-1:0] z
	);
		return ADDR_W'((int'(x) * CHUNK_EDGE + int'(y)) * CHUNK_EDGE + int'(z));
	endfunction

	// unit cube corner offsets as {x, y, z}
	function automatic logic [2:0] cube_corner(input logic [2:0] idx);
		logic [2:0] u;
		case (idx)
			3'd0:    u = 3'b000;
			3'd1:    u = 3'b100;
			3'd2:    u = 3'b010;
			3'd3:    u = 3'b001;
			3'd4:    u = 3'b110;
			3'd5:    u = 3'b101;
			3'd6:    u = 3'b011;
			3'd7:    u = 3'b111;
			default: u = 3'b000;
		endcase
		return u;
	endfunction

	// corner indexes of each triangle as {a, b, c}, two per face
	function automatic logic [8:0] tri_corners(input logic [3:0] tri_idx);
		logic [8:0] t;
		case (tri_idx)
			4'd0:    t = {3'd0, 3'd3, 3'd6};
			4'd1:    t = {3'd6, 3'd2, 3'd0};
			4'd2:    t = {3'd0, 3'd1, 3'd5};
			4'd3:    t = {3'd5, 3'd3, 3'd0};
			4'd4:    t = {3'd0, 3'd2, 3'd4};
			4'd5:    t = {3'd4, 3'd1, 3'd0};
			4'd6:    t = {3'd7, 3'd5, 3'd1};
			4'd7:    t = {3'd1, 3'd4, 3'd7};
			4'd8:    t = {3'd7, 3'd4, 3'd2};
			4'd9:    t = {3'd2, 3'd6, 3'd7};
			4'd10:   t = {3'd7, 3'd6, 3'd3};
			4'd11:   t = {3'd3, 3'd5, 3'd7};
			default: t = {3'd0, 3'd0, 3'd0};
		endcase
		return t;
	endfunction

	// base plus unit offset, clamped to the coordinate range
	function automatic logic [COORD_W-1:0] world_coord(
		input logic [BASE_W-1:0] base,
		input logic              unit
	);
		logic [BASE_W-1:0] sum;
		logic [BASE_W-1:0] res;
		sum = base + BASE_W'(unit);
		if ($signed(sum) > $signed(BASE_W'(COORD_MAX))) begin
			res = BASE_W'(COORD_MAX);
		end else if ($signed(sum) < $signed(BASE_W'(COORD_MIN))) begin
			res = BASE_W'(COORD_MIN);
		end else begin
			res = sum;
		end
		return res[COORD_W-1:0];
	endfunction

endpackage

### design/voxel_face_culling_mesher_top.sv
// top level of the voxel face culling mesher: configuration registers and the two halves
`timescale 1ns / 1ps

// Voxel face culling mesher.
// Request channel: a word is taken on a clock edge with push high and full low.
// A write word stores new_type (not the unused type) for one voxel of the 8x8x8 chunk;
// a mesh word names a voxel and yields one result word per visible triangle (up to
// twelve), or a single word with tri_valid low when the voxel is air or fully hidden.
// Result channel: the oldest result sits on the ports while empty is low and is
// taken on an edge with pop high. last_tri marks the final word of a request.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data set the chunk
// coordinates; cfg_ready is always high. Write only while the block is idle.
// A two-word request queue sits in front. A write is stored as the back end takes it.
// A mesh request reads the center and its six neighbors through the single read port
// of the voxel store, then emits its result words. A stalled result channel holds the
// back end while the front still takes words until its queue is full. Reset clears the
// queues and the chunk coordinates; voxel contents stay undefined until written.
module voxel_face_culling_mesher_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 req_type,
	input  logic [vfcm_pkg::VOX_W-1:0]           voxel_x,
	input  logic [vfcm_pkg::VOX_W-1:0]           voxel_y,
	input  logic [vfcm_pkg::VOX_W-1:0]           voxel_z,
	input  logic [vfcm_pkg::TYPE_W-1:0]          new_type,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_a_x,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_a_y,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_a_z,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_b_x,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_b_y,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_b_z,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_c_x,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_c_y,
	output logic signed [vfcm_pkg::COORD_W-1:0]  corner_c_z,
	output logic [vfcm_pkg::TYPE_W-1:0]          face_type,
	output logic                                 tri_valid,
	output logic                                 last_tri,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vfcm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vfcm_pkg::CHUNK_W-1:0]         cfg_data
);

	logic [vfcm_pkg::CHUNK_W-1:0] chunk_x_q, chunk_y_q, chunk_z_q;
	vfcm_pkg::front_item_t        item;
	vfcm_pkg::tri_word_t          word;
	logic                         avail;
	logic                         take;
	logic                         out_valid;

	// chunk coordinate registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_x_q <= '0;
			chunk_y_q <= '0;
			chunk_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				vfcm_pkg::REG_CHUNK_X: chunk_x_q <= cfg_data;
				vfcm_pkg::REG_CHUNK_Y: chunk_y_q <= cfg_data;
				vfcm_pkg::REG_CHUNK_Z: chunk_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vfcm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.voxel_x  (voxel_x),
		.voxel_y  (voxel_y),
		.voxel_z  (voxel_z),
		.new_type (new_type),
		.take     (take),
		.avail    (avail),
		.item     (item)
	);

	vfcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.item      (item),
		.take      (take),
		.chunk_x   (chunk_x_q),
		.chunk_y   (chunk_y_q),
		.chunk_z   (chunk_z_q),
		.pop       (pop),
		.out_valid (out_valid),
		.out_word  (word)
	);

	// result ports
	assign empty      = !out_valid;
	assign corner_a_x = word.corner_a_x;
	assign corner_a_y = word.corner_a_y;
	assign corner_a_z = word.corner_a_z;
	assign corner_b_x = word.corner_b_x;
	assign corner_b_y = word.corner_b_y;
	assign corner_b_z = word.corner_b_z;
	assign corner_c_x = word.corner_c_x;
	assign corner_c_y = word.corner_c_y;
	assign corner_c_z = word.corner_c_z;
	assign face_type  = word.face_type;
	assign tri_valid  = word.tri_valid;
	assign last_tri   = word.last_tri;

endmodule

### design/vfcm_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module vfcm_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/vfcm_front.sv
// front end: takes request words, classifies them and queues them for the back end
`timescale 1ns / 1ps

module vfcm_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         req_type,
	input  logic [vfcm_pkg::VOX_W-1:0]   voxel_x,
	input  logic [vfcm_pkg::VOX_W-1:0]   voxel_y,
	input  logic [vfcm_pkg::VOX_W-1:0]   voxel_z,
	input  logic [vfcm_pkg::TYPE_W-1:0]  new_type,
	input  logic                         take,
	output logic                         avail,
	output vfcm_pkg::front_item_t        item
);

	vfcm_pkg::front_item_t slot_q [2];
	vfcm_pkg::front_item_t cls;
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push_ok;
	logic                  pop_ok;

	// classify the incoming word
	always_comb begin
		cls.is_mesh  = (req_type == vfcm_pkg::REQ_MESH);
		cls.x        = voxel_x;
		cls.y        = voxel_y;
		cls.z        = voxel_z;
		cls.new_type = new_type;
		cls.in_chunk = (int'(voxel_x) < vfcm_pkg::CHUNK_EDGE) &&
		               (int'(voxel_y) < vfcm_pkg::CHUNK_EDGE) &&
		               (int'(voxel_z) < vfcm_pkg::CHUNK_EDGE);
		cls.nbr_in[vfcm_pkg::FACE_XN] = (voxel_x != '0);
		cls.nbr_in[vfcm_pkg::FACE_YN] = (voxel_y != '0);
		cls.nbr_in[vfcm_pkg::FACE_ZN] = (voxel_z != '0);
		cls.nbr_in[vfcm_pkg::FACE_XP] = (int'(voxel_x) + 1 < vfcm_pkg::CHUNK_EDGE);
		cls.nbr_in[vfcm_pkg::FACE_YP] = (int'(voxel_y) + 1 < vfcm_pkg::CHUNK_EDGE);
		cls.nbr_in[vfcm_pkg::FACE_ZP] = (int'(voxel_z) + 1 < vfcm_pkg::CHUNK_EDGE);
	end

	assign full    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign push_ok = push && !full;
	assign pop_ok  = take && avail;
	assign item    = slot_q[rd_ptr_q];

	// two entry queue storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/vfcm_back.sv
// back end: voxel store, neighbor scan and triangle emission into the result register
`timescale 1ns / 1ps

module vfcm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          avail,
	input  vfcm_pkg::front_item_t         item,
	output logic                          take,
	input  logic [vfcm_pkg::CHUNK_W-1:0]  chunk_x,
	input  logic [vfcm_pkg::CHUNK_W-1:0]  chunk_y,
	input  logic [vfcm_pkg::CHUNK_W-1:0]  chunk_z,
	input  logic                          pop,
	output logic                          out_valid,
	output vfcm_pkg::tri_word_t           out_word
);

	vfcm_pkg::bk_state_t           state_q, state_d;
	vfcm_pkg::front_item_t         cur_q;
	logic [vfcm_pkg::BASE_W-1:0]   base_x_q, base_y_q, base_z_q;
	logic [2:0]                    rd_cnt_q;
	logic [vfcm_pkg::TYPE_W-1:0]   vt_q;
	logic [vfcm_pkg::FACES-1:0]    open_q;
	logic [vfcm_pkg::FACES-1:0]    pend_q;
	logic                          half_q;
	logic                          out_valid_q;
	vfcm_pkg::tri_word_t           out_q;

	logic                          ram_we;
	logic [vfcm_pkg::ADDR_W-1:0]   ram_waddr;
	logic [vfcm_pkg::ADDR_W-1:0]   ram_raddr;
	logic [vfcm_pkg::TYPE_W-1:0]   ram_rdata;

	logic [2:0]                    rd_face;
	logic [2:0]                    data_face;
	logic [vfcm_pkg::VOX_W-1:0]    nx, ny, nz;
	logic                          face_open_now;
	logic [vfcm_pkg::FACES-1:0]    open_full;
	logic [2:0]                    cur_face;
	logic [vfcm_pkg::FACES-1:0]    cur_bit;
	logic                          out_load;
	logic                          emit_last;
	logic [3:0]                    tri_idx;
	logic [8:0]                    tri_c;
	logic [2:0]                    ua, ub, uc;
	vfcm_pkg::tri_word_t           word_d;

	vfcm_ram #(
		.WIDTH(vfcm_pkg::TYPE_W),
		.DEPTH(vfcm_pkg::VOXEL_COUNT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item.new_type),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// write requests go straight to the store
	assign take      = (state_q == vfcm_pkg::BK_IDLE) && avail;
	assign ram_we    = take && !item.is_mesh && item.in_chunk &&
	                   (item.new_type != vfcm_pkg::TYPE_UNUSED);
	assign ram_waddr = vfcm_pkg::cell_addr(item.x, item.y, item.z);

	// read address: center first, then the six neighbors
	assign rd_face   = rd_cnt_q - 3'd1;
	always_comb begin
		nx = cur_q.x;
		ny = cur_q.y;
		nz = cur_q.z;
		case (rd_face)
			vfcm_pkg::FACE_XN: nx = cur_q.x - 3'd1;
			vfcm_pkg::FACE_YN: ny = cur_q.y - 3'd1;
			vfcm_pkg::FACE_ZN: nz = cur_q.z - 3'd1;
			vfcm_pkg::FACE_XP: nx = cur_q.x + 3'd1;
			vfcm_pkg::FACE_YP: ny = cur_q.y + 3'd1;
			vfcm_pkg::FACE_ZP: nz = cur_q.z + 3'd1;
			default: begin
				nx = cur_q.x;
				ny = cur_q.y;
				nz = cur_q.z;
			end
		endcase
		if (rd_cnt_q == 3'd0) begin
			ram_raddr = vfcm_pkg::cell_addr(cur_q.x, cur_q.y, cur_q.z);
		end else begin
			ram_raddr = vfcm_pkg::cell_addr(nx, ny, nz);
		end
	end

	// neighbor test on the word read in the cycle before
	assign data_face     = rd_cnt_q - 3'd2;
	assign face_open_now = !cur_q.nbr_in[data_face] || (ram_rdata == vfcm_pkg::TYPE_AIR);
	assign open_full     = {face_open_now, open_q[vfcm_pkg::FACES-2:0]};

	// lowest face still to emit
	always_comb begin
		cur_face = 3'd0;
		for (int i = vfcm_pkg::FACES - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				cur_face = 3'(i);
			end
		end
		cur_bit = vfcm_pkg::FACES'(1) << cur_face;
	end

	assign tri_idx = {cur_face, half_q};
	assign tri_c   = vfcm_pkg::tri_corners(tri_idx);
	assign ua      = vfcm_pkg::cube_corner(tri_c[8:6]);
	assign ub      = vfcm_pkg::cube_corner(tri_c[5:3]);
	assign uc      = vfcm_pkg::cube_corner(tri_c[2:0]);

	// result word for the current triangle or the no-triangle marker
	always_comb begin
		if (pend_q == '0) begin
			word_d            = '0;
			word_d.face_type  = vt_q;
			word_d.tri_valid  = 1'b0;
			word_d.last_tri   = 1'b1;
			emit_last         = 1'b1;
		end else begin
			emit_last         = half_q && ((pend_q & ~cur_bit) == '0);
			word_d.corner_a_x = vfcm_pkg::world_coord(base_x_q, ua[2]);
			word_d.corner_a_y = vfcm_pkg::world_coord(base_y_q, ua[1]);
			word_d.corner_a_z = vfcm_pkg::world_coord(base_z_q, ua[0]);
			word_d.corner_b_x = vfcm_pkg::world_coord(base_x_q, ub[2]);
			word_d.corner_b_y = vfcm_pkg::world_coord(base_y_q, ub[1]);
			word_d.corner_b_z = vfcm_pkg::world_coord(base_z_q, ub[0]);
			word_d.corner_c_x = vfcm_pkg::world_coord(base_x_q, uc[2]);
			word_d.corner_c_y = vfcm_pkg::world_coord(base_y_q, uc[1]);
			word_d.corner_c_z = vfcm_pkg::world_coord(base_z_q, uc[0]);
			word_d.face_type  = vt_q;
			word_d.tri_valid  = 1'b1;
			word_d.last_tri   = emit_last;
		end
	end

	assign out_load = (state_q == vfcm_pkg::BK_EMIT) && (!out_valid_q || pop);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vfcm_pkg::BK_IDLE: begin
				if (take && item.is_mesh) begin
					state_d = vfcm_pkg::BK_READ;
				end
			end
			vfcm_pkg::BK_READ: begin
				if (rd_cnt_q == 3'd7) begin
					state_d = vfcm_pkg::BK_EMIT;
				end
			end
			vfcm_pkg::BK_EMIT: begin
				if (out_load && emit_last) begin
					state_d = vfcm_pkg::BK_IDLE;
				end
			end
			default: state_d = vfcm_pkg::BK_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfcm_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request context, scan results and emission progress
	always_ff @(posedge clk) begin
		if (take && item.is_mesh) begin
			cur_q    <= item;
			rd_cnt_q <= 3'd0;
			base_x_q <= vfcm_pkg::BASE_W'($signed(chunk_x) * vfcm_pkg::CHUNK_EDGE) +
			            vfcm_pkg::BASE_W'(item.x);
			base_y_q <= vfcm_pkg::BASE_W'($signed(chunk_y) * vfcm_pkg::CHUNK_EDGE) +
			            vfcm_pkg::BASE_W'(item.y);
			base_z_q <= vfcm_pkg::BASE_W'($signed(chunk_z) * vfcm_pkg::CHUNK_EDGE) +
			            vfcm_pkg::BASE_W'(item.z);
		end
		if (state_q == vfcm_pkg::BK_READ) begin
			rd_cnt_q <= rd_cnt_q + 3'd1;
			if (rd_cnt_q == 3'd1) begin
				vt_q <= cur_q.in_chunk ? ram_rdata : vfcm_pkg::TYPE_AIR;
			end
			if (rd_cnt_q >= 3'd2) begin
				open_q[data_face] <= face_open_now;
			end
			if (rd_cnt_q == 3'd7) begin
				pend_q <= (vt_q != vfcm_pkg::TYPE_AIR) ? open_full : '0;
				half_q <= 1'b0;
			end
		end
		if (out_load && (pend_q != '0)) begin
			half_q <= !half_q;
			if (half_q) begin
				pend_q <= pend_q & ~cur_bit;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= word_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### tb/tb_voxel_face_culling_mesher_top.sv
// self-checking testbench for the voxel face culling mesher top level
`timescale 1ns / 1ps

module tb_voxel_face_culling_mesher_top;
	import vfcm_pkg::*;

	// block types with no name in the package
	localparam logic [TYPE_W-1:0] TYPE_RED  = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_BLUE = 2'd2;
	// register index past the last chunk coordinate, written to check it is ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_STRETCH  = 300;
	localparam int REPORT_MAX    = 10;

	// unit cube corner offsets {x, y, z}
	localparam int CORNER_OFF [8][3] = '{
		'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1},
		'{1, 1, 0}, '{1, 0, 1}, '{0, 1, 1}, '{1, 1, 1}
	};
	// corner indexes of the two triangles of each face, faces in x-, y-, z-, x+, y+, z+ order
	localparam int TRI_IDX [12][3] = '{
		'{0, 3, 6}, '{6, 2, 0}, '{0, 1, 5}, '{5, 3, 0},
		'{0, 2, 4}, '{4, 1, 0}, '{7, 5, 1}, '{1, 4, 7},
		'{7, 4, 2}, '{2, 6, 7}, '{7, 6, 3}, '{3, 5, 7}
	};
	// neighbor step of each face
	localparam int STEP [FACES][3] = '{
		'{-1, 0, 0}, '{0, -1, 0}, '{0, 0, -1},
		'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}
	};

	// directed row: a request, and for single no-triangle answers the type it must carry
	typedef struct packed {
		logic              req;
		logic [VOX_W-1:0]  x;
		logic [VOX_W-1:0]  y;
		logic [VOX_W-1:0]  z;
		logic [TYPE_W-1:0] nt;
		logic              none_chk;
		logic [TYPE_W-1:0] none_type;
	} dir_row_t;

	localparam int DIR_LEN = 22;
	localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
		// corner voxel with solid neighbors on the inside: only the outer faces show
		'{REQ_WRITE, 3'd0, 3'd0, 3'd0, TYPE_BLUE, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd1, 3'd0, 3'd0, TYPE_RED, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd0, 3'd1, 3'd0, TYPE_RED, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd0, 3'd0, 3'd1, TYPE_RED, 1'b0, TYPE_AIR},
		'{REQ_MESH, 3'd0, 3'd0, 3'd0, TYPE_AIR, 1'b0, TYPE_AIR},
		// unused type is dropped, voxel stays blue
		'{REQ_WRITE, 3'd0, 3'd0, 3'd0, TYPE_UNUSED, 1'b0, TYPE_AIR},
		'{REQ_MESH, 3'd0, 3'd0, 3'd0, TYPE_AIR, 1'b0, TYPE_AIR},
		// air voxel answers with one empty word
		'{REQ_WRITE, 3'd0, 3'd0, 3'd0, TYPE_AIR, 1'b0, TYPE_AIR},
		'{REQ_MESH, 3'd0, 3'd0, 3'd0, TYPE_AIR, 1'b1, TYPE_AIR},
		// interior voxel boxed in on all six sides
		'{REQ_WRITE, 3'd3, 3'd4, 3'd5, TYPE_RED, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd2, 3'd4, 3'd5, TYPE_BLUE, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd4, 3'd4, 3'd5, TYPE_BLUE, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd3, 3'd3, 3'd5, TYPE_BLUE, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd3, 3'd5, 3'd5, TYPE_BLUE, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd3, 3'd4, 3'd4, TYPE_BLUE, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd3, 3'd4, 3'd6, TYPE_BLUE, 1'b0, TYPE_AIR},
		'{REQ_MESH, 3'd3, 3'd4, 3'd5, TYPE_AIR, 1'b1, TYPE_RED},
		// far corner with air inside: all twelve triangles
		'{REQ_WRITE, 3'd7, 3'd7, 3'd7, TYPE_BLUE, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd6, 3'd7, 3'd7, TYPE_AIR, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd7, 3'd6, 3'd7, TYPE_AIR, 1'b0, TYPE_AIR},
		'{REQ_WRITE, 3'd7, 3'd7, 3'd6, TYPE_AIR, 1'b0, TYPE_AIR},
		'{REQ_MESH, 3'd7, 3'd7, 3'd7, TYPE_AIR, 1'b0, TYPE_AIR}
	};

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic                       req_type = REQ_WRITE;
	logic [VOX_W-1:0]           voxel_x = '0;
	logic [VOX_W-1:0]           voxel_y = '0;
	logic [VOX_W-1:0]           voxel_z = '0;
	logic [TYPE_W-1:0]          new_type = TYPE_AIR;
	logic                       empty;
	logic                       pop = 1'b0;
	logic signed [COORD_W-1:0]  corner_a_x, corner_a_y, corner_a_z;
	logic signed [COORD_W-1:0]  corner_b_x, corner_b_y, corner_b_z;
	logic signed [COORD_W-1:0]  corner_c_x, corner_c_y, corner_c_z;
	logic [TYPE_W-1:0]          face_type;
	logic                       tri_valid;
	logic                       last_tri;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_CHUNK_X;
	logic [CHUNK_W-1:0]         cfg_data = '0;

	// shadow of the chunk and its position
	logic [TYPE_W-1:0]          voxel_mirror [VOXEL_COUNT];
	bit                         voxel_known [VOXEL_COUNT];
	logic signed [CHUNK_W-1:0]  chunk_pos [3];

	// triangle words still owed by the block, oldest first
	tri_word_t                  pending_tris [$];

	int send_idle = 0;
	int recv_idle = 0;
	int hold_cycles = 0;
	int cycle_count = 0;
	int fail_count = 0;
	int req_count = 0;
	int mesh_count = 0;
	int word_count = 0;
	int empty_words = 0;
	int cfg_count = 0;
	int stall_cycles = 0;

	voxel_face_culling_mesher_top i_dut (.*);

	// clock and cycle count
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("voxel_face_culling_mesher_top regression: fail");
		$finish;
	end

	function automatic int slot(input int x, input int y, input int z);
		return (x * CHUNK_EDGE + y) * CHUNK_EDGE + z;
	endfunction

	// one world coordinate, clamped to the output range
	function automatic logic [COORD_W-1:0] world_pos(input logic signed [CHUNK_W-1:0] chunk,
			input int vox, input int unit);
		int v;
		v = int'(chunk) * CHUNK_EDGE + vox + unit;
		if (v > COORD_MAX) v = COORD_MAX;
		if (v < COORD_MIN) v = COORD_MIN;
		return v[COORD_W-1:0];
	endfunction

	function automatic tri_word_t no_tri_word(input logic [TYPE_W-1:0] vt);
		tri_word_t w;
		w = '0;
		w.face_type = vt;
		w.last_tri = 1'b1;
		return w;
	endfunction

	// a voxel may be meshed once it and every neighbor inside the chunk hold a type
	function automatic bit meshable(input int x, input int y, input int z);
		int n[3];
		bit ok;
		ok = voxel_known[slot(x, y, z)];
		for (int f = 0; f < FACES; f++) begin
			n = '{x + STEP[f][0], y + STEP[f][1], z + STEP[f][2]};
			if (n[0] >= 0 && n[1] >= 0 && n[2] >= 0 &&
				n[0] < CHUNK_EDGE && n[1] < CHUNK_EDGE && n[2] < CHUNK_EDGE)
				ok &= voxel_known[slot(n[0], n[1], n[2])];
		end
		return ok;
	endfunction

	function automatic string tri_str(input tri_word_t t);
		return $sformatf("a(%h %h %h) b(%h %h %h) c(%h %h %h) type %0d valid %0b last %0b",
			t.corner_a_x, t.corner_a_y, t.corner_a_z, t.corner_b_x, t.corner_b_y,
			t.corner_b_z, t.corner_c_x, t.corner_c_y, t.corner_c_z, t.face_type,
			t.tri_valid, t.last_tri);
	endfunction

	// triangles of the visible faces of one voxel
	task automatic predict_mesh(input int x, input int y, input int z);
		tri_word_t words [$];
		tri_word_t w;
		logic [COORD_W-1:0] co [9];
		logic [TYPE_W-1:0] vt;
		int pos[3];
		int n[3];
		int corner;
		bit open;
		pos = '{x, y, z};
		vt = voxel_mirror[slot(x, y, z)];
		if (vt != TYPE_AIR) begin
			for (int f = 0; f < FACES; f++) begin
				n = '{x + STEP[f][0], y + STEP[f][1], z + STEP[f][2]};
				if (n[0] < 0 || n[1] < 0 || n[2] < 0 ||
					n[0] >= CHUNK_EDGE || n[1] >= CHUNK_EDGE || n[2] >= CHUNK_EDGE)
					open = 1'b1;
				else
					open = (voxel_mirror[slot(n[0], n[1], n[2])] == TYPE_AIR);
				if (!open) continue;
				for (int t = 0; t < 2; t++) begin
					for (int c = 0; c < 3; c++) begin
						corner = TRI_IDX[f * 2 + t][c];
						for (int a = 0; a < 3; a++)
							co[c * 3 + a] = world_pos(chunk_pos[a], pos[a], CORNER_OFF[corner][a]);
					end
					w = '{co[0], co[1], co[2], co[3], co[4], co[5], co[6], co[7], co[8],
						vt, 1'b1, 1'b0};
					words.push_back(w);
				end
			end
		end
		if (words.size() == 0)
			words.push_back(no_tri_word(vt));
		else
			words[words.size() - 1].last_tri = 1'b1;
		foreach (words[i]) pending_tris.push_back(words[i]);
	endtask

	// offer one request word and update the shadow when it is taken
	task automatic send_req(input logic req, input int x, input int y, input int z,
			input logic [TYPE_W-1:0] nt, input bit typed = 1'b0,
			input logic [TYPE_W-1:0] typed_vt = TYPE_AIR);
		while ($urandom_range(0, 99) < send_idle) begin
			@(negedge clk);
			push = 1'b0;
		end
		@(negedge clk);
		push = 1'b1;
		req_type = req;
		voxel_x = VOX_W'(x);
		voxel_y = VOX_W'(y);
		voxel_z = VOX_W'(z);
		new_type = nt;
		@(posedge clk);
		while (full) begin
			stall_cycles++;
			@(posedge clk);
		end
		req_count++;
		if (req == REQ_WRITE) begin
			if (nt != TYPE_UNUSED) begin
				voxel_mirror[slot(x, y, z)] = nt;
				voxel_known[slot(x, y, z)] = 1'b1;
			end
		end else begin
			mesh_count++;
			if (typed) pending_tris.push_back(no_tri_word(typed_vt));
			else predict_mesh(x, y, z);
		end
	endtask

	// stop offering, wait out every owed word and any trailing write
	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (pending_tris.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CHUNK_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_count++;
		case (idx)
			REG_CHUNK_X: chunk_pos[0] = data;
			REG_CHUNK_Y: chunk_pos[1] = data;
			REG_CHUNK_Z: chunk_pos[2] = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_chunk(input logic [CHUNK_W-1:0] cx, input logic [CHUNK_W-1:0] cy,
			input logic [CHUNK_W-1:0] cz);
		cfg_write(REG_CHUNK_X, cx);
		cfg_write(REG_SPARE, CHUNK_W'($urandom_range(0, 65535)));
		cfg_write(REG_CHUNK_Y, cy);
		cfg_write(REG_CHUNK_Z, cz);
	endtask

	// random traffic: mostly fill-a-neighborhood-then-mesh runs, plus loose meshes and writes
	task automatic random_burst(input int n);
		int left, kind, x, y, z, tries;
		int nb[3];
		logic [TYPE_W-1:0] nt;
		bit dense, found;
		left = n;
		while (left > 0) begin
			kind = $urandom_range(0, 99);
			x = $urandom_range(0, CHUNK_EDGE - 1);
			y = $urandom_range(0, CHUNK_EDGE - 1);
			z = $urandom_range(0, CHUNK_EDGE - 1);
			if (kind < 50) begin
				dense = ($urandom_range(0, 3) == 0);
				for (int f = 0; f < FACES; f++) begin
					nb = '{x + STEP[f][0], y + STEP[f][1], z + STEP[f][2]};
					if (nb[0] < 0 || nb[1] < 0 || nb[2] < 0 ||
						nb[0] >= CHUNK_EDGE || nb[1] >= CHUNK_EDGE || nb[2] >= CHUNK_EDGE)
						continue;
					if (voxel_known[slot(nb[0], nb[1], nb[2])] && $urandom_range(0, 1)) continue;
					nt = dense ? TYPE_W'($urandom_range(1, 2)) : TYPE_W'($urandom_range(0, 2));
					send_req(REQ_WRITE, nb[0], nb[1], nb[2], nt);
					left--;
				end
				nt = ($urandom_range(0, 5) == 0) ? TYPE_AIR : TYPE_W'($urandom_range(1, 2));
				send_req(REQ_WRITE, x, y, z, nt);
				send_req(REQ_MESH, x, y, z, TYPE_W'($urandom_range(0, 3)));
				left -= 2;
			end else if (kind < 80) begin
				found = meshable(x, y, z);
				tries = 0;
				while (!found && tries < 8) begin
					x = $urandom_range(0, CHUNK_EDGE - 1);
					y = $urandom_range(0, CHUNK_EDGE - 1);
					z = $urandom_range(0, CHUNK_EDGE - 1);
					found = meshable(x, y, z);
					tries++;
				end
				if (found) send_req(REQ_MESH, x, y, z, TYPE_W'($urandom_range(0, 3)));
				else send_req(REQ_WRITE, x, y, z, TYPE_W'($urandom_range(0, 2)));
				left--;
			end else begin
				nt = TYPE_W'($urandom_range(0, 3));
				send_req(REQ_WRITE, x, y, z, nt);
				if (nt != TYPE_UNUSED) left--;
			end
		end
	endtask

	// result side: random pops, long hold-off on request, compare against the oldest owed word
	initial begin
		tri_word_t got, want;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				pop = 1'b0;
				hold_cycles--;
			end else begin
				pop = ($urandom_range(0, 99) >= recv_idle);
			end
			@(posedge clk);
			if (pop && !empty) begin
				got = '{corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
					corner_c_x, corner_c_y, corner_c_z, face_type, tri_valid, last_tri};
				word_count++;
				if (!got.tri_valid) empty_words++;
				if (pending_tris.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("[%0t] unexpected word: %s", $realtime, tri_str(got));
					fail_count++;
				end else begin
					want = pending_tris.pop_front();
					if (got !== want) begin
						if (fail_count < REPORT_MAX) begin
							$display("[%0t] word mismatch", $realtime);
							$display("  expected %s", tri_str(want));
							$display("  actual   %s", tri_str(got));
						end
						fail_count++;
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t row;
		foreach (voxel_mirror[i]) begin
			voxel_mirror[i] = TYPE_AIR;
			voxel_known[i] = 1'b0;
		end
		foreach (chunk_pos[i]) chunk_pos[i] = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table at reset chunk position, sender 36 and receiver 78 percent idle
		send_idle = 36;
		recv_idle = 78;
		for (int i = 0; i < DIR_LEN; i++) begin
			row = DIR_ROWS[i];
			send_req(row.req, row.x, row.y, row.z, row.nt, row.none_chk, row.none_type);
		end
		settle();

		// upper x and lower y limits hit the coordinate clamp bounds exactly
		set_chunk(16'sh7fff, 16'sh8000, 16'shffff);
		random_burst(120);
		settle();

		// mirrored limits, idling swapped
		send_idle = 78;
		recv_idle = 36;
		set_chunk(16'sh8000, 16'sh7fff, CHUNK_W'($urandom_range(0, 65535)));
		random_burst(120);
		settle();

		// no idling, with one long receiver hold-off so the input backs up
		send_idle = 0;
		recv_idle = 0;
		set_chunk(CHUNK_W'($urandom_range(0, 65535)), CHUNK_W'($urandom_range(0, 65535)),
			CHUNK_W'($urandom_range(0, 65535)));
		hold_cycles = HOLD_STRETCH;
		random_burst(110);
		settle();

		fail_count += pending_tris.size();
		$display("covered %0d requests (%0d mesh), %0d result words (%0d without triangles)",
			req_count, mesh_count, word_count, empty_words);
		$display("%0d register writes over four chunk positions, input held off %0d cycles",
			cfg_count, stall_cycles);
		if (fail_count == 0) begin
			$display("voxel_face_culling_mesher_top regression: pass");
		end else begin
			$display("voxel_face_culling_mesher_top regression: fail");
		end
		$finish;
	end

endmodule

### sim.f
design/vfcm_pkg.sv
design/vfcm_ram.sv
design/vfcm_front.sv
design/vfcm_back.sv
design/voxel_face_culling_mesher_top.sv
tb/tb_voxel_face_culling_mesher_top.sv
